// File: rtl/pcfc_pkg.sv
// shared types, register codes and helpers for the pixel color filter chain
`default_nettype none

package pcfc_pkg;

   // input item: pixel position and rgba
   typedef struct packed {
      logic [11:0] col;
      logic [11:0] row;
      logic [7:0]  red_in;
      logic [7:0]  green_in;
      logic [7:0]  blue_in;
      logic [7:0]  alpha_in;
   } req_payload_type;

   // result item: filtered rgba
   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [7:0] alpha_out;
   } rsp_payload_type;

   // register port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH       = 3'd0,
      CSR_IMAGE_HEIGHT      = 3'd1,
      CSR_BRIGHTNESS_OFFSET = 3'd2,
      CSR_SATURATION_GAIN   = 3'd3,
      CSR_LUMA_KEY_MODE     = 3'd4,
      CSR_LUMA_THRESHOLD    = 3'd5,
      CSR_VIGNETTE_COEF     = 3'd6
   } csr_index_type;

   // luma key modes, the unused code behaves as off
   typedef enum logic [1:0] {
      KEY_OFF    = 2'd0,
      KEY_DARK   = 2'd1,
      KEY_BRIGHT = 2'd2
   } key_mode_type;

   // register widths
   localparam int DIM_W    = 13;
   localparam int BOFS_W   = 9;
   localparam int GAIN_W   = 12;
   localparam int THR_W    = 16;
   localparam int COEF_W   = 24;

   // datapath widths
   localparam int LUMA_W   = 16;
   localparam int OFS_W    = 14;
   localparam int SQ_W     = 26;
   localparam int D2_W     = 27;
   localparam int SAT_W    = 31;
   localparam int PPLO_W   = 38;
   localparam int PPHI_W   = 37;
   localparam int PROD_W   = 51;
   localparam int FACTOR_W = 17;

   // register reset values
   localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH    = 13'd1;
   localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT   = 13'd1;
   localparam logic [BOFS_W-1:0] RST_BRIGHTNESS     = 9'd0;
   localparam logic [GAIN_W-1:0] RST_SATURATION     = 12'd256;
   localparam logic [1:0]        RST_KEY_MODE       = KEY_OFF;
   localparam logic [THR_W-1:0]  RST_LUMA_THRESHOLD = 16'd32640;
   localparam logic [COEF_W-1:0] RST_VIGNETTE_COEF  = 24'd0;

   // luma weights in 1/256
   localparam logic [LUMA_W-1:0] LUMA_R = 16'd77;
   localparam logic [LUMA_W-1:0] LUMA_G = 16'd150;
   localparam logic [LUMA_W-1:0] LUMA_B = 16'd29;

   // luma in q8.8 from three 8 bit channels
   function automatic logic [LUMA_W-1:0] luma(input logic [7:0] r,
                                              input logic [7:0] g,
                                              input logic [7:0] b);
      return LUMA_R * LUMA_W'(r) + LUMA_G * LUMA_W'(g) + LUMA_B * LUMA_W'(b);
   endfunction

endpackage

`default_nettype wire

// File: rtl/pixel_color_filter_chain.sv
// pixel color filter chain: brightness, saturation, luma key, vignette
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_ready   pcfc_pkg::req_payload_type
//   rsp_      out        rsp_valid / rsp_ready   pcfc_pkg::rsp_payload_type
//   csr_      in         csr_we                  csr_index, csr_wdata
//
// one item per cycle while the output is not stalled, through six register
// stages. the depth comes from the vignette distance square, the split
// 24x27 coefficient multiply and the final scaling multiply, each behind
// its own register.
// synchronous reset empties the pipeline and loads the register defaults.
// a stalled output holds every stage; req_ready is low only while a result
// waits and rsp_ready is low.
`default_nettype none

module pixel_color_filter_chain #(
   parameter int MAX_DIM = 4096
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire pcfc_pkg::req_payload_type     req_payload,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output pcfc_pkg::rsp_payload_type          rsp_payload,
   input  wire                                csr_we,
   input  wire [pcfc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire [pcfc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int DIM_W    = pcfc_pkg::DIM_W;
   localparam int LUMA_W   = pcfc_pkg::LUMA_W;
   localparam int OFS_W    = pcfc_pkg::OFS_W;
   localparam int SQ_W     = pcfc_pkg::SQ_W;
   localparam int D2_W     = pcfc_pkg::D2_W;
   localparam int SAT_W    = pcfc_pkg::SAT_W;
   localparam int PPLO_W   = pcfc_pkg::PPLO_W;
   localparam int PPHI_W   = pcfc_pkg::PPHI_W;
   localparam int PROD_W   = pcfc_pkg::PROD_W;
   localparam int FACTOR_W = pcfc_pkg::FACTOR_W;
   localparam int COEF_W   = pcfc_pkg::COEF_W;
   localparam int D2_LO_W  = 14;
   localparam int CMP_W    = 15;
   localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);

   // configuration registers
   logic [DIM_W-1:0]              image_width_ff;
   logic [DIM_W-1:0]              image_height_ff;
   logic [pcfc_pkg::BOFS_W-1:0]   brightness_offset_ff;
   logic [pcfc_pkg::GAIN_W-1:0]   saturation_gain_ff;
   logic [1:0]                    luma_key_mode_ff;
   logic [pcfc_pkg::THR_W-1:0]    luma_threshold_ff;
   logic [COEF_W-1:0]             vignette_coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff       <= pcfc_pkg::RST_IMAGE_WIDTH;
         image_height_ff      <= pcfc_pkg::RST_IMAGE_HEIGHT;
         brightness_offset_ff <= pcfc_pkg::RST_BRIGHTNESS;
         saturation_gain_ff   <= pcfc_pkg::RST_SATURATION;
         luma_key_mode_ff     <= pcfc_pkg::RST_KEY_MODE;
         luma_threshold_ff    <= pcfc_pkg::RST_LUMA_THRESHOLD;
         vignette_coef_ff     <= pcfc_pkg::RST_VIGNETTE_COEF;
      end else if (csr_we) begin
         unique case (csr_index)
            pcfc_pkg::CSR_IMAGE_WIDTH:       image_width_ff <= csr_wdata[DIM_W-1:0];
            pcfc_pkg::CSR_IMAGE_HEIGHT:      image_height_ff <= csr_wdata[DIM_W-1:0];
            pcfc_pkg::CSR_BRIGHTNESS_OFFSET:
               brightness_offset_ff <= csr_wdata[pcfc_pkg::BOFS_W-1:0];
            pcfc_pkg::CSR_SATURATION_GAIN:
               saturation_gain_ff <= csr_wdata[pcfc_pkg::GAIN_W-1:0];
            pcfc_pkg::CSR_LUMA_KEY_MODE:     luma_key_mode_ff <= csr_wdata[1:0];
            pcfc_pkg::CSR_LUMA_THRESHOLD:
               luma_threshold_ff <= csr_wdata[pcfc_pkg::THR_W-1:0];
            pcfc_pkg::CSR_VIGNETTE_COEF:     vignette_coef_ff <= csr_wdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves unless the output holds a waiting item
   logic advance;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;

   assign advance   = !s6_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   // stage 1: brightness and offsets from the frame centre
   logic [7:0]             s1_c_in [3];
   logic [7:0]             s1_c_ff [3];
   logic [7:0]             s1_a_ff;
   logic signed [OFS_W-1:0] s1_dx_in, s1_dy_in, s1_dx_ff, s1_dy_ff;

   always_comb begin
      logic [7:0]        px [3];
      logic signed [9:0] bofs;
      logic signed [9:0] bsum;
      logic [DIM_W-1:0]  w_eff;
      logic [DIM_W-1:0]  h_eff;
      logic signed [CMP_W-1:0] dx_full;
      logic signed [CMP_W-1:0] dy_full;
      px[0] = req_payload.red_in;
      px[1] = req_payload.green_in;
      px[2] = req_payload.blue_in;
      bofs  = $signed({brightness_offset_ff[8], brightness_offset_ff});
      for (int i = 0; i < 3; i++) begin
         bsum = $signed({2'b00, px[i]}) + bofs;
         if (bsum < 0) begin
            s1_c_in[i] = 8'd0;
         end else if (bsum > 10'sd255) begin
            s1_c_in[i] = 8'd255;
         end else begin
            s1_c_in[i] = bsum[7:0];
         end
      end
      // frame size saturates at the largest supported dimension
      w_eff = ({2'b00, image_width_ff} > MAX_DIM_C) ? MAX_DIM_C[DIM_W-1:0] : image_width_ff;
      h_eff = ({2'b00, image_height_ff} > MAX_DIM_C) ? MAX_DIM_C[DIM_W-1:0] : image_height_ff;
      dx_full  = $signed({2'b00, req_payload.col, 1'b0}) - $signed({2'b00, w_eff});
      dy_full  = $signed({2'b00, req_payload.row, 1'b0}) - $signed({2'b00, h_eff});
      s1_dx_in = dx_full[OFS_W-1:0];
      s1_dy_in = dy_full[OFS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_c_ff  <= s1_c_in;
         s1_a_ff  <= req_payload.alpha_in;
         s1_dx_ff <= s1_dx_in;
         s1_dy_ff <= s1_dy_in;
      end
   end

   // stage 2: luma of the brightened pixel and distance squares
   logic [LUMA_W-1:0] s2_lum_ff;
   logic [7:0]        s2_c_ff [3];
   logic [7:0]        s2_a_ff;
   logic [SQ_W-1:0]   s2_dx2_ff, s2_dy2_ff;
   logic signed [2*OFS_W-1:0] dx_sq, dy_sq;

   assign dx_sq = s1_dx_ff * s1_dx_ff;
   assign dy_sq = s1_dy_ff * s1_dy_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_lum_ff <= pcfc_pkg::luma(s1_c_ff[0], s1_c_ff[1], s1_c_ff[2]);
         s2_c_ff   <= s1_c_ff;
         s2_a_ff   <= s1_a_ff;
         s2_dx2_ff <= dx_sq[SQ_W-1:0];
         s2_dy2_ff <= dy_sq[SQ_W-1:0];
      end
   end

   // stage 3: saturation blend toward luma
   logic signed [SAT_W-1:0] s3_v_in [3];
   logic signed [SAT_W-1:0] s3_v_ff [3];
   logic [7:0]              s3_a_ff;
   logic [D2_W-1:0]         s3_d2_ff;

   always_comb begin
      logic signed [17:0]      diff;
      logic signed [SAT_W-1:0] scaled;
      for (int i = 0; i < 3; i++) begin
         diff       = $signed({2'b00, s2_c_ff[i], 8'h00}) - $signed({2'b00, s2_lum_ff});
         scaled     = $signed({1'b0, saturation_gain_ff}) * diff;
         s3_v_in[i] = scaled + $signed({7'd0, s2_lum_ff, 8'h00});
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_v_ff  <= s3_v_in;
         s3_a_ff  <= s2_a_ff;
         s3_d2_ff <= {1'b0, s2_dx2_ff} + {1'b0, s2_dy2_ff};
      end
   end

   // stage 4: saturation clamp and split coefficient product
   logic [7:0]        s4_c_in [3];
   logic [7:0]        s4_c_ff [3];
   logic [7:0]        s4_a_ff;
   logic [PPLO_W-1:0] s4_pplo_ff;
   logic [PPHI_W-1:0] s4_pphi_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (s3_v_ff[i][SAT_W-1]) begin
            s4_c_in[i] = 8'd0;
         end else if (|s3_v_ff[i][SAT_W-2:24]) begin
            s4_c_in[i] = 8'd255;
         end else begin
            s4_c_in[i] = s3_v_ff[i][23:16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_c_ff    <= s4_c_in;
         s4_a_ff    <= s3_a_ff;
         s4_pplo_ff <= PPLO_W'(vignette_coef_ff) * PPLO_W'(s3_d2_ff[D2_LO_W-1:0]);
         s4_pphi_ff <= PPHI_W'(vignette_coef_ff) * PPHI_W'(s3_d2_ff[D2_W-1:D2_LO_W]);
      end
   end

   // stage 5: vignette factor and luma of the saturated pixel
   logic [FACTOR_W-1:0] s5_factor_in, s5_factor_ff;
   logic [LUMA_W-1:0]   s5_lum_ff;
   logic [7:0]          s5_c_ff [3];
   logic [7:0]          s5_a_ff;

   always_comb begin
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] rounded;
      prod    = PROD_W'(s4_pplo_ff) + {s4_pphi_ff, {D2_LO_W{1'b0}}};
      // ceiling of prod / 2^16
      rounded = prod + PROD_W'(16'hFFFF);
      if (|rounded[PROD_W-1:32]) begin
         s5_factor_in = '0;
      end else begin
         s5_factor_in = 17'h10000 - {1'b0, rounded[31:16]};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_factor_ff <= s5_factor_in;
         s5_lum_ff    <= pcfc_pkg::luma(s4_c_ff[0], s4_c_ff[1], s4_c_ff[2]);
         s5_c_ff      <= s4_c_ff;
         s5_a_ff      <= s4_a_ff;
      end
   end

   // stage 6: luma key and vignette scaling into the output register
   pcfc_pkg::rsp_payload_type s6_out_in, s6_out_ff;

   always_comb begin
      logic [24:0] m [3];
      logic        clear;
      for (int i = 0; i < 3; i++) begin
         m[i] = 25'(s5_c_ff[i]) * 25'(s5_factor_ff);
      end
      case (luma_key_mode_ff)
         pcfc_pkg::KEY_DARK:   clear = s5_lum_ff < luma_threshold_ff;
         pcfc_pkg::KEY_BRIGHT: clear = s5_lum_ff > luma_threshold_ff;
         default:              clear = 1'b0;
      endcase
      s6_out_in.red_out   = m[0][23:16];
      s6_out_in.green_out = m[1][23:16];
      s6_out_in.blue_out  = m[2][23:16];
      s6_out_in.alpha_out = clear ? 8'd0 : s5_a_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_out_ff <= s6_out_in;
      end
   end

   assign rsp_valid   = s6_valid_ff;
   assign rsp_payload = s6_out_ff;

endmodule

`default_nettype wire

// File: rtl/pcfc_checker.sv
// port-level checks for the pixel color filter chain and their bind
`default_nettype none

module pcfc_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_valid,
   input wire                            req_ready,
   input wire pcfc_pkg::req_payload_type req_payload,
   input wire                            rsp_valid,
   input wire                            rsp_ready,
   input wire pcfc_pkg::rsp_payload_type rsp_payload
);

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // a waiting item holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("waiting result changed or dropped");

   // an offered input item stays put until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_payload))
      else $error("offered input item changed or dropped");

   // an empty output never blocks input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

   // a stalled output holds the whole pipeline
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

endmodule

bind pixel_color_filter_chain pcfc_checker u_pcfc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
